/* rtl/dsqrt_pkg.sv */
// Shared types and constants for the decimal digit square root core.
// Used by the controller, the datapath and the top level; depends on nothing.
package dsqrt_pkg;

    localparam int MAX_INPUT_DIGITS    = 16;
    localparam int MAX_FRACTION_DIGITS = 8;

    localparam int BCD_W    = 64;
    localparam int COUNT_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int FRAC_W   = 4;
    localparam int REM_W    = 64;
    localparam int ROOT_W   = 54;
    localparam int BASE_W   = ROOT_W + 5;
    localparam int PROD_W   = BASE_W + DIGIT_W;
    localparam int PAIR_W   = 3;
    localparam int TBIT_W   = 2;
    localparam int GROUP_W  = 7;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SPECIAL,
        ST_SHIFT,
        ST_TRIAL,
        ST_EMIT
    } dsqrt_state_t;

    typedef struct packed {
        logic load;
        logic shift_in;
        logic trial;
        logic apply;
        logic special;
    } dsqrt_cmd_t;

    typedef struct packed {
        logic bad_input;
        logic lead_zero;
        logic trial_last;
        logic out_free;
        logic last_digit;
    } dsqrt_status_t;

endpackage

/* rtl/dsqrt_ctrl.sv */
// Controller state machine of the decimal digit square root core.
// Depends on dsqrt_pkg; drives commands to dsqrt_dp and reads its status.
module dsqrt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  dsqrt_pkg::dsqrt_status_t status,
    output dsqrt_pkg::dsqrt_cmd_t    cmd,
    output dsqrt_pkg::dsqrt_state_t  state
);

    dsqrt_pkg::dsqrt_state_t state_reg;
    dsqrt_pkg::dsqrt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsqrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsqrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dsqrt_pkg::ST_CLASSIFY;
                end
            end
            dsqrt_pkg::ST_CLASSIFY:
            begin
                if (status.bad_input || status.lead_zero)
                begin
                    state_next = dsqrt_pkg::ST_SPECIAL;
                end
                else
                begin
                    state_next = dsqrt_pkg::ST_SHIFT;
                end
            end
            dsqrt_pkg::ST_SPECIAL:
            begin
                if (status.out_free)
                begin
                    state_next = dsqrt_pkg::ST_IDLE;
                end
            end
            dsqrt_pkg::ST_SHIFT:
            begin
                state_next = dsqrt_pkg::ST_TRIAL;
            end
            dsqrt_pkg::ST_TRIAL:
            begin
                if (status.trial_last)
                begin
                    state_next = dsqrt_pkg::ST_EMIT;
                end
            end
            dsqrt_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (status.last_digit)
                    begin
                        state_next = dsqrt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dsqrt_pkg::ST_SHIFT;
                    end
                end
            end
            default:
            begin
                state_next = dsqrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            dsqrt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            dsqrt_pkg::ST_SPECIAL:
            begin
                cmd.special = status.out_free;
            end
            dsqrt_pkg::ST_SHIFT:
            begin
                cmd.shift_in = 1'b1;
            end
            dsqrt_pkg::ST_TRIAL:
            begin
                cmd.trial = 1'b1;
            end
            dsqrt_pkg::ST_EMIT:
            begin
                cmd.apply = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

/* rtl/dsqrt_dp.sv */
// Datapath of the decimal digit square root core: operand, remainder, root,
// shared trial multiply-compare unit and output register. Depends on dsqrt_pkg.
module dsqrt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dsqrt_pkg::dsqrt_cmd_t                cmd,
    output dsqrt_pkg::dsqrt_status_t             status,
    input  logic [dsqrt_pkg::BCD_W-1:0]          number_bcd,
    input  logic [dsqrt_pkg::COUNT_W-1:0]        digit_count,
    input  logic                                 cfg_we,
    input  logic [dsqrt_pkg::FRAC_W-1:0]         cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dsqrt_pkg::DIGIT_W-1:0]        root_digit,
    output logic                                 integer_part,
    output logic                                 error,
    output logic                                 last
);

    logic [dsqrt_pkg::FRAC_W-1:0]  frac_cfg_reg;
    logic [dsqrt_pkg::BCD_W-1:0]   bcd_reg;
    logic [dsqrt_pkg::COUNT_W-1:0] count_reg;
    logic [dsqrt_pkg::REM_W-1:0]   rem_reg;
    logic [dsqrt_pkg::ROOT_W-1:0]  root_reg;
    logic [dsqrt_pkg::BASE_W-1:0]  base_reg;
    logic [dsqrt_pkg::DIGIT_W-1:0] d_reg;
    logic [dsqrt_pkg::REM_W-1:0]   prod_reg;
    logic [dsqrt_pkg::TBIT_W-1:0]  tbit_reg;
    logic [dsqrt_pkg::PAIR_W-1:0]  pair_reg;
    logic                          integer_reg;
    logic [dsqrt_pkg::FRAC_W-1:0]  frac_left_reg;
    logic                          out_valid_reg;
    logic [dsqrt_pkg::DIGIT_W-1:0] out_digit_reg;
    logic                          out_int_reg;
    logic                          out_err_reg;
    logic                          out_last_reg;

    logic [dsqrt_pkg::BCD_W-1:0]   bcd_masked;
    logic [dsqrt_pkg::COUNT_W-1:0] count_m1_in;
    logic [dsqrt_pkg::FRAC_W-1:0]  frac_clamped;
    logic [dsqrt_pkg::COUNT_W-1:0] count_m1;
    logic                          nibble_bad;
    logic                          bad_input;
    logic [dsqrt_pkg::DIGIT_W-1:0] top_nibble;
    logic [7:0]                    pair_byte;
    logic [dsqrt_pkg::GROUP_W-1:0] group_val;
    logic [dsqrt_pkg::REM_W-1:0]   rem_shifted;
    logic [dsqrt_pkg::DIGIT_W-1:0] cand;
    logic [dsqrt_pkg::BASE_W-1:0]  trial_sum;
    logic [dsqrt_pkg::PROD_W-1:0]  trial_prod;
    logic                          trial_fits;
    logic [dsqrt_pkg::REM_W-1:0]   rem_diff;
    logic [dsqrt_pkg::ROOT_W-1:0]  root_times10;
    logic                          last_digit;
    logic                          out_free;

    always_comb
    begin
        for (int i = 0; i < dsqrt_pkg::MAX_INPUT_DIGITS; i++)
        begin
            if (dsqrt_pkg::COUNT_W'(i) < digit_count)
            begin
                bcd_masked[4*i +: 4] = number_bcd[4*i +: 4];
            end
            else
            begin
                bcd_masked[4*i +: 4] = 4'd0;
            end
        end
    end

    assign count_m1_in  = digit_count - dsqrt_pkg::COUNT_W'(1);
    assign frac_clamped = (frac_cfg_reg > dsqrt_pkg::FRAC_W'(dsqrt_pkg::MAX_FRACTION_DIGITS))
                        ? dsqrt_pkg::FRAC_W'(dsqrt_pkg::MAX_FRACTION_DIGITS) : frac_cfg_reg;

    always_comb
    begin
        nibble_bad = 1'b0;
        for (int i = 0; i < dsqrt_pkg::MAX_INPUT_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] > dsqrt_pkg::DIGIT_MAX)
            begin
                nibble_bad = 1'b1;
            end
        end
    end

    assign count_m1   = count_reg - dsqrt_pkg::COUNT_W'(1);
    assign bad_input  = (count_reg == '0)
                     || (count_reg > dsqrt_pkg::COUNT_W'(dsqrt_pkg::MAX_INPUT_DIGITS))
                     || nibble_bad;
    assign top_nibble = bcd_reg[4*count_m1[3:0] +: 4];

    assign pair_byte   = integer_reg ? bcd_reg[8*pair_reg +: 8] : 8'd0;
    assign group_val   = {pair_byte[7:4], 3'b000} + {2'b00, pair_byte[7:4], 1'b0}
                       + {3'b000, pair_byte[3:0]};
    assign rem_shifted = {rem_reg[57:0], 6'b0} + {rem_reg[58:0], 5'b0}
                       + {rem_reg[61:0], 2'b0}
                       + {{(dsqrt_pkg::REM_W-dsqrt_pkg::GROUP_W){1'b0}}, group_val};

    assign cand       = d_reg | (dsqrt_pkg::DIGIT_W'(1) << tbit_reg);
    assign trial_sum  = base_reg + {{(dsqrt_pkg::BASE_W-dsqrt_pkg::DIGIT_W){1'b0}}, cand};
    assign trial_prod = {{dsqrt_pkg::DIGIT_W{1'b0}}, trial_sum}
                      * {{dsqrt_pkg::BASE_W{1'b0}}, cand};
    assign trial_fits = (cand <= dsqrt_pkg::DIGIT_MAX)
                     && ({{(dsqrt_pkg::REM_W-dsqrt_pkg::PROD_W){1'b0}}, trial_prod} <= rem_reg);

    assign rem_diff     = rem_reg - prod_reg;
    assign root_times10 = {root_reg[50:0], 3'b0} + {root_reg[52:0], 1'b0}
                        + {{(dsqrt_pkg::ROOT_W-dsqrt_pkg::DIGIT_W){1'b0}}, d_reg};
    assign last_digit   = integer_reg
                        ? ((pair_reg == '0) && ((frac_left_reg == '0) || (rem_diff == '0)))
                        : (frac_left_reg == dsqrt_pkg::FRAC_W'(1));
    assign out_free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_cfg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frac_cfg_reg <= cfg_data;
            end
            if (cmd.apply || cmd.special)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bcd_reg       <= bcd_masked;
            count_reg     <= digit_count;
            rem_reg       <= '0;
            root_reg      <= '0;
            pair_reg      <= count_m1_in[dsqrt_pkg::PAIR_W:1];
            integer_reg   <= 1'b1;
            frac_left_reg <= frac_clamped;
        end
        if (cmd.shift_in)
        begin
            rem_reg  <= rem_shifted;
            base_reg <= {1'b0, root_reg, 4'b0} + {3'b000, root_reg, 2'b0};
            d_reg    <= '0;
            prod_reg <= '0;
            tbit_reg <= '1;
        end
        if (cmd.trial)
        begin
            tbit_reg <= tbit_reg - dsqrt_pkg::TBIT_W'(1);
            if (trial_fits)
            begin
                d_reg    <= cand;
                prod_reg <= {{(dsqrt_pkg::REM_W-dsqrt_pkg::PROD_W){1'b0}}, trial_prod};
            end
        end
        if (cmd.apply)
        begin
            rem_reg       <= rem_diff;
            root_reg      <= root_times10;
            out_digit_reg <= d_reg;
            out_int_reg   <= integer_reg;
            out_err_reg   <= 1'b0;
            out_last_reg  <= last_digit;
            if (integer_reg)
            begin
                if (pair_reg == '0)
                begin
                    integer_reg <= 1'b0;
                end
                else
                begin
                    pair_reg <= pair_reg - dsqrt_pkg::PAIR_W'(1);
                end
            end
            else
            begin
                frac_left_reg <= frac_left_reg - dsqrt_pkg::FRAC_W'(1);
            end
        end
        if (cmd.special)
        begin
            out_digit_reg <= '0;
            out_int_reg   <= !bad_input;
            out_err_reg   <= bad_input;
            out_last_reg  <= 1'b1;
        end
    end

    always_comb
    begin
        status            = '0;
        status.bad_input  = bad_input;
        status.lead_zero  = (top_nibble == '0);
        status.trial_last = (tbit_reg == '0);
        status.out_free   = out_free;
        status.last_digit = last_digit;
    end

    assign out_valid    = out_valid_reg;
    assign root_digit   = out_digit_reg;
    assign integer_part = out_int_reg;
    assign error        = out_err_reg;
    assign last         = out_last_reg;

endmodule

/* rtl/decimal_digit_square_root_core.sv */
// Top level of the decimal digit square root core.
// Joins dsqrt_ctrl and dsqrt_dp; depends on dsqrt_pkg.
//
// Usage: a request on the input channel (in_valid, in_stall) carries up to
// sixteen BCD digits in number_bcd and their count in digit_count. The core
// answers on the output channel (out_valid, out_stall) with one request per
// root digit, most significant first, and marks the final one with last.
// The integer digits come first, then fraction_digits fraction digits (at
// most eight) unless the number is a perfect square. A bad count or a
// non-decimal digit gives a single request with error set.
// The configuration channel (cfg_valid, cfg_ready) writes fraction_digits;
// it is always ready and is meant to be written while the core is idle.
// Operation: one item is worked on at a time. After acceptance the core
// classifies the operand; each root digit is then found in a step that
// brings down the next digit pair, four trial multiply-compare steps on
// the shared trial unit to find the digit, and a step that updates the
// remainder and loads the output register.
// A stalled receiver holds the core in the digit-output step until the
// output register frees up. Reset clears the controller, the output valid
// flag and fraction_digits; no clearing pass is needed.
module decimal_digit_square_root_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dsqrt_pkg::BCD_W-1:0]          number_bcd,
    input  logic [dsqrt_pkg::COUNT_W-1:0]        digit_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dsqrt_pkg::DIGIT_W-1:0]        root_digit,
    output logic                                 integer_part,
    output logic                                 error,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsqrt_pkg::FRAC_W-1:0]         fraction_digits
);

    dsqrt_pkg::dsqrt_cmd_t    cmd;
    dsqrt_pkg::dsqrt_status_t status;
    dsqrt_pkg::dsqrt_state_t  state;

    assign cfg_ready = 1'b1;

    dsqrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    dsqrt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .number_bcd   (number_bcd),
        .digit_count  (digit_count),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (fraction_digits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .root_digit   (root_digit),
        .integer_part (integer_part),
        .error        (error),
        .last         (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state == dsqrt_pkg::ST_CLASSIFY))
        else $error("Accepted request did not start classification.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (last && (root_digit == '0) && !integer_part))
        else $error("Error result is not a single cleared final result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (root_digit <= dsqrt_pkg::DIGIT_MAX))
        else $error("Root digit is not decimal.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply || cmd.special) |-> status.out_free)
        else $error("Output register loaded while still occupied.");

endmodule

/* bench/tb_decimal_digit_square_root_core.sv */
// Self-checking testbench for decimal_digit_square_root_core: random and directed
// requests checked digit by digit against a long-hand square root worked out here.
// Depends on dsqrt_pkg and the RTL of the core; reads no files.
module tb_decimal_digit_square_root_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [dsqrt_pkg::DIGIT_W-1:0] digit;
        logic                          integer_part;
        logic                          error;
        logic                          last;
    } root_digit_t;

    class sqrt_scoreboard;
        root_digit_t                  pending_root_digits[$];
        logic [dsqrt_pkg::FRAC_W-1:0] fraction_setting;
        int                           mismatches;

        function new();
            fraction_setting = '0;
            mismatches = 0;
        endfunction

        function logic [dsqrt_pkg::DIGIT_W-1:0] operand_digit(
            logic [dsqrt_pkg::BCD_W-1:0] bcd, int i, int count);
            if (i >= count || i >= dsqrt_pkg::MAX_INPUT_DIGITS)
                return '0;
            return bcd[4*i +: 4];
        endfunction

        function logic [dsqrt_pkg::DIGIT_W-1:0] next_root_digit(
            inout logic [dsqrt_pkg::REM_W-1:0] rem,
            inout logic [dsqrt_pkg::ROOT_W-1:0] root);
            logic [dsqrt_pkg::REM_W-1:0]   base;
            logic [dsqrt_pkg::DIGIT_W-1:0] d;
            d = dsqrt_pkg::DIGIT_MAX;
            base = dsqrt_pkg::REM_W'(root) * 20;
            while (d > 0 && (base + d) * d > rem)
                d--;
            rem = rem - (base + d) * d;
            root = root * 10 + d;
            return d;
        endfunction

        function void note_operand(logic [dsqrt_pkg::BCD_W-1:0] bcd,
                                   logic [dsqrt_pkg::COUNT_W-1:0] count);
            logic [dsqrt_pkg::REM_W-1:0]   rem;
            logic [dsqrt_pkg::ROOT_W-1:0]  root;
            logic [dsqrt_pkg::DIGIT_W-1:0] d;
            logic                          fin;
            int                            groups;
            int                            frac;
            int                            lo;
            int                            i;
            int                            j;
            rem = '0;
            root = '0;
            if (count == 0 || count > dsqrt_pkg::MAX_INPUT_DIGITS)
            begin
                pending_root_digits.push_back(root_digit_t'{4'd0, 1'b0, 1'b1, 1'b1});
                return;
            end
            for (i = 0; i < count; i++)
            begin
                if (operand_digit(bcd, i, count) > 9)
                begin
                    pending_root_digits.push_back(root_digit_t'{4'd0, 1'b0, 1'b1, 1'b1});
                    return;
                end
            end
            if (operand_digit(bcd, count - 1, count) == 0)
            begin
                pending_root_digits.push_back(root_digit_t'{4'd0, 1'b1, 1'b0, 1'b1});
                return;
            end
            frac = (fraction_setting > dsqrt_pkg::MAX_FRACTION_DIGITS)
                 ? dsqrt_pkg::MAX_FRACTION_DIGITS : fraction_setting;
            groups = (count + 1) / 2;
            for (j = 0; j < groups; j++)
            begin
                lo = 2 * (groups - 1 - j);
                rem = rem * 100 + operand_digit(bcd, lo + 1, count) * 10
                      + operand_digit(bcd, lo, count);
                d = next_root_digit(rem, root);
                fin = (j + 1 == groups) && (frac == 0 || rem == 0);
                pending_root_digits.push_back(root_digit_t'{d, 1'b1, 1'b0, fin});
            end
            if (rem == 0)
                return;
            for (j = 0; j < frac; j++)
            begin
                rem = rem * 100;
                d = next_root_digit(rem, root);
                pending_root_digits.push_back(root_digit_t'{d, 1'b0, 1'b0, j + 1 == frac});
            end
        endfunction

        function void check_root_digit(root_digit_t got);
            root_digit_t want;
            if (pending_root_digits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 30)
                    $display("%0t: unexpected result, expected none, %s %0d %0b %0b %0b",
                             $time, "got digit/int/err/last", got.digit,
                             got.integer_part, got.error, got.last);
                return;
            end
            want = pending_root_digits.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 30)
                    $display("%0t: expected digit %0d int %0b err %0b last %0b, %s",
                             $time, want.digit, want.integer_part, want.error, want.last,
                             $sformatf("got digit %0d int %0b err %0b last %0b",
                                       got.digit, got.integer_part, got.error, got.last));
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [dsqrt_pkg::BCD_W-1:0]     number_bcd;
    logic [dsqrt_pkg::COUNT_W-1:0]   digit_count;
    logic                            out_valid;
    logic                            out_stall;
    logic [dsqrt_pkg::DIGIT_W-1:0]   root_digit;
    logic                            integer_part;
    logic                            error;
    logic                            last;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dsqrt_pkg::FRAC_W-1:0]    fraction_digits;

    sqrt_scoreboard board = new();
    bit             sender_no_gaps = 1'b0;
    int             digits_seen = 0;
    int             quiet_cycles = 0;

    decimal_digit_square_root_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .number_bcd      (number_bcd),
        .digit_count     (digit_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .root_digit      (root_digit),
        .integer_part    (integer_part),
        .error           (error),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fraction_digits (fraction_digits)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_operand(input logic [dsqrt_pkg::BCD_W-1:0] bcd,
                                input logic [dsqrt_pkg::COUNT_W-1:0] count);
        int gap;
        gap = sender_no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        number_bcd  <= bcd;
        digit_count <= count;
        do @(posedge clk); while (in_stall);
        board.note_operand(bcd, count);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_root_digits.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_fraction_digits(input logic [dsqrt_pkg::FRAC_W-1:0] value);
        wait_for_drain();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid       <= 1'b1;
        fraction_digits <= value;
        do @(posedge clk); while (!cfg_ready);
        board.fraction_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_operand(output logic [dsqrt_pkg::BCD_W-1:0] bcd,
                                  output logic [dsqrt_pkg::COUNT_W-1:0] count);
        int                          kind;
        int                          i;
        int                          r;
        logic [dsqrt_pkg::BCD_W-1:0] square;
        kind  = $urandom_range(0, 99);
        bcd   = {$urandom, $urandom};
        count = dsqrt_pkg::COUNT_W'($urandom_range(1, dsqrt_pkg::MAX_INPUT_DIGITS));
        if (kind < 15)
        begin
            r = $urandom_range(1, 99999999) >> $urandom_range(0, 26);
            if (r == 0)
                r = 1;
            square = dsqrt_pkg::BCD_W'(r) * dsqrt_pkg::BCD_W'(r);
            count = '0;
            while (square != 0)
            begin
                bcd[4*count +: 4] = dsqrt_pkg::DIGIT_W'(square % 10);
                square = square / 10;
                count++;
            end
        end
        else
        begin
            for (i = 0; i < count; i++)
                bcd[4*i +: 4] = dsqrt_pkg::DIGIT_W'($urandom_range(0, 9));
            if (kind < 80)
                bcd[4*(count-1) +: 4] = dsqrt_pkg::DIGIT_W'($urandom_range(1, 9));
            else if (kind < 86)
                bcd[4*(count-1) +: 4] = '0;
            else if (kind < 92)
                bcd[4*$urandom_range(0, count - 1) +: 4] =
                    dsqrt_pkg::DIGIT_W'($urandom_range(10, 15));
            else if (kind < 96)
                count = $urandom_range(0, 1) ? dsqrt_pkg::COUNT_W'(0)
                                             : dsqrt_pkg::COUNT_W'($urandom_range(17, 31));
            else
                count = dsqrt_pkg::COUNT_W'($urandom);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_root_digit(root_digit_t'{root_digit, integer_part, error, last});
            digits_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_decimal_digit_square_root_core NOT OK");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so that the core backs up
    // and stalls its input while requests are still being offered.
    initial
    begin
        int run;
        bit long_hold_done;
        long_hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && digits_seen >= 200)
            begin
                long_hold_done = 1'b1;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            run = pick_gap();
            if (run > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (run - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 99) < 10) ? 40 : $urandom_range(0, 4)) @(negedge clk);
        end
    end

    initial
    begin
        logic [dsqrt_pkg::BCD_W-1:0]   bcd;
        logic [dsqrt_pkg::COUNT_W-1:0] count;
        int                            phase;
        int                            n;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        number_bcd      = '0;
        digit_count     = '0;
        cfg_valid       = 1'b0;
        fraction_digits = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_operand(64'h0, 5'd0);
        send_operand(64'h5, 5'd17);
        send_operand(64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
        send_operand(64'hA, 5'd1);
        send_operand(64'hF999_9999_9999_9999, 5'd16);
        send_operand(64'hFFFF_FFFF_FFFF_FF81, 5'd2);
        send_operand(64'h045, 5'd3);
        send_operand(64'h0, 5'd1);
        send_operand(64'h2, 5'd1);
        send_operand(64'h10001, 5'd5);

        write_fraction_digits(4'd8);
        send_operand(64'h2, 5'd1);
        send_operand(64'h10001, 5'd5);
        send_operand(64'h100, 5'd3);
        send_operand(64'h9999_9999_9999_9999, 5'd16);
        send_operand(64'h1000_0000_0000_0000, 5'd16);
        send_operand(64'h1, 5'd1);
        send_operand(64'h99, 5'd2);

        write_fraction_digits(4'd15);
        send_operand(64'h3, 5'd1);
        send_operand(64'h9999_9999_9999_9999, 5'd16);
        send_operand(64'h1000_0000_0000_0001, 5'd16);
        send_operand(64'h8000_0000_0000_0000, 5'd16);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_fraction_digits(4'd15);
                1: write_fraction_digits(4'd0);
                2: write_fraction_digits(4'd8);
                default: write_fraction_digits(dsqrt_pkg::FRAC_W'($urandom_range(0, 15)));
            endcase
            sender_no_gaps = (phase == 2);
            for (n = 0; n < 20; n++)
            begin
                if (phase == 3 && n == 10)
                    wait_for_drain();
                random_operand(bcd, count);
                send_operand(bcd, count);
            end
        end
        sender_no_gaps = 1'b0;

        wait_for_drain();
        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending_root_digits.size() == 0)
            $display("tb_decimal_digit_square_root_core OK");
        else
            $display("tb_decimal_digit_square_root_core NOT OK");
        $finish;
    end
endmodule
